[hdl/asc_pkg.sv]
// types, constants and register indexes shared by the alarm siren controller
`timescale 1ns / 1ps
package asc_pkg;

   localparam int TIMER_BITS_DEFAULT = 16;
   localparam int CFG_TICK_BITS      = 16;
   localparam int CFG_LIMIT_BITS     = 4;
   localparam int CFG_DATA_BITS      = 16;
   localparam int CFG_INDEX_BITS     = 2;
   localparam int TALLY_BITS         = 5;

   localparam logic [CFG_TICK_BITS-1:0]  SIREN_TICKS_RESET = 16'd300;
   localparam logic [CFG_TICK_BITS-1:0]  ALARM_TICKS_RESET = 16'd1200;
   localparam logic [CFG_LIMIT_BITS-1:0] MAX_ALARMS_RESET  = 4'd3;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_TRIGGER = 2'd1,
      OP_STOP    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_ACTIVE  = 2'd1,
      MODE_TIMEOUT = 2'd2
   } mode_type;

   typedef enum logic [CFG_INDEX_BITS-1:0] {
      REG_SIREN_TICKS = 2'd0,
      REG_ALARM_TICKS = 2'd1,
      REG_MAX_ALARMS  = 2'd2
   } reg_index_type;

endpackage

[hdl/asc_ifs.sv]
// request and response channel interfaces of the alarm siren controller
`timescale 1ns / 1ps
interface asc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [3:0] event_source;

   modport source (output valid, output operation, output event_source, input ready);
   modport sink   (input valid, input operation, input event_source, output ready);
endinterface

interface asc_rsp_if;
   logic       valid;
   logic       ready;
   logic       siren_out;
   logic [1:0] alarm_mode;
   logic       cancel_valid;
   logic [3:0] cancel_source;
   logic [4:0] trigger_count;

   modport source (output valid, output siren_out, output alarm_mode, output cancel_valid,
                   output cancel_source, output trigger_count, input ready);
   modport sink   (input valid, input siren_out, input alarm_mode, input cancel_valid,
                   input cancel_source, input trigger_count, output ready);
endinterface

[hdl/alarm_siren_controller.sv]
// alarm siren controller top level
//
// req_chan carries one event per transaction: tick, trigger or stop, plus
// the source of a stop. rsp_chan returns exactly one transaction per request
// with the siren level, the mode, a cancel flag with its source and the
// trigger count, all as they stand after that event.
// the csr port writes siren_ticks, alarm_ticks and max_alarms by index;
// the user is to write it only while no request is in flight, which the
// block itself does not enforce. a request accepted on req_chan is held in
// the request register, then presented on rsp_chan from the response
// register. throughput: one transaction per cycle while rsp_chan takes
// responses, set by the single state update between the two registers.
// on a rsp_chan stall the response register holds and the request register
// takes one more; req_chan.ready then drops until the response is taken.
// reset clears both registers' valid flags, the mode, siren, countdowns and
// trigger count, and loads the configuration defaults (300, 1200, 3).
// unused operation codes change nothing and report the current state.
`timescale 1ns / 1ps
module alarm_siren_controller #(
   parameter int TIMER_BITS = asc_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   asc_req_if.sink                             req_chan,
   asc_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [asc_pkg::CFG_INDEX_BITS-1:0]  csr_index,
   input  logic [asc_pkg::CFG_DATA_BITS-1:0]   csr_wdata
);
   import asc_pkg::*;

   // configuration
   logic [CFG_TICK_BITS-1:0]  siren_ticks_ff;
   logic [CFG_TICK_BITS-1:0]  alarm_ticks_ff;
   logic [CFG_LIMIT_BITS-1:0] max_alarms_ff;

   // request register
   logic       req_valid_ff;
   logic [1:0] req_op_ff;
   logic [3:0] req_src_ff;

   // controller state
   mode_type                mode_ff, mode_in;
   logic                    siren_ff, siren_in;
   logic [TIMER_BITS-1:0]   siren_cd_ff, siren_cd_in;
   logic [TIMER_BITS-1:0]   alarm_cd_ff, alarm_cd_in;
   logic [TALLY_BITS-1:0]   tally_ff, tally_in;
   logic                    cancel_in;
   logic [3:0]              cancel_src_in;

   // response register
   logic                    rsp_valid_ff;
   logic                    rsp_siren_ff;
   logic [1:0]              rsp_mode_ff;
   logic                    rsp_cancel_ff;
   logic [3:0]              rsp_cancel_src_ff;
   logic [TALLY_BITS-1:0]   rsp_tally_ff;

   logic                    advance;
   logic                    req_take;
   logic [TALLY_BITS-1:0]   max_ext;
   logic [TALLY_BITS-1:0]   tally_up;
   logic [TIMER_BITS-1:0]   siren_load;
   logic [TIMER_BITS-1:0]   alarm_load;
   logic [TIMER_BITS-1:0]   siren_dec;
   logic [TIMER_BITS-1:0]   alarm_dec;

   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign max_ext    = {1'b0, max_alarms_ff};
   assign tally_up   = tally_ff + TALLY_BITS'(1);
   assign siren_load = TIMER_BITS'(siren_ticks_ff);
   assign alarm_load = TIMER_BITS'(alarm_ticks_ff);
   assign siren_dec  = siren_cd_ff - TIMER_BITS'(1);
   assign alarm_dec  = alarm_cd_ff - TIMER_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         siren_ticks_ff <= SIREN_TICKS_RESET;
         alarm_ticks_ff <= ALARM_TICKS_RESET;
         max_alarms_ff  <= MAX_ALARMS_RESET;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_SIREN_TICKS: siren_ticks_ff <= csr_wdata[CFG_TICK_BITS-1:0];
            REG_ALARM_TICKS: alarm_ticks_ff <= csr_wdata[CFG_TICK_BITS-1:0];
            REG_MAX_ALARMS:  max_alarms_ff  <= csr_wdata[CFG_LIMIT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_op_ff  <= req_chan.operation;
         req_src_ff <= req_chan.event_source;
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      siren_in      = siren_ff;
      siren_cd_in   = siren_cd_ff;
      alarm_cd_in   = alarm_cd_ff;
      tally_in      = tally_ff;
      cancel_in     = 1'b0;
      cancel_src_in = 4'd0;
      case (op_type'(req_op_ff))
         OP_TICK: begin
            if (siren_cd_ff != '0) begin
               siren_cd_in = siren_dec;
               if (siren_dec == '0) begin
                  siren_in = 1'b0;
               end
            end
            if (alarm_cd_ff != '0) begin
               alarm_cd_in = alarm_dec;
               if (alarm_dec == '0) begin
                  mode_in = MODE_TIMEOUT;
               end
            end
         end
         OP_TRIGGER: begin
            if (mode_ff != MODE_ACTIVE) begin
               if (tally_ff <= max_ext) begin
                  tally_in = tally_up;
               end
               if (tally_in <= max_ext) begin
                  mode_in     = MODE_ACTIVE;
                  alarm_cd_in = alarm_load;
                  if (!siren_ff) begin
                     siren_cd_in = siren_load;
                     siren_in    = 1'b1;
                  end
               end
            end
         end
         OP_STOP: begin
            if (mode_ff == MODE_ACTIVE) begin
               cancel_in     = 1'b1;
               cancel_src_in = req_src_ff;
            end
            siren_in    = 1'b0;
            siren_cd_in = '0;
            alarm_cd_in = '0;
            tally_in    = '0;
            mode_in     = MODE_IDLE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         siren_ff    <= 1'b0;
         siren_cd_ff <= '0;
         alarm_cd_ff <= '0;
         tally_ff    <= '0;
      end else if (advance) begin
         mode_ff     <= mode_in;
         siren_ff    <= siren_in;
         siren_cd_ff <= siren_cd_in;
         alarm_cd_ff <= alarm_cd_in;
         tally_ff    <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_siren_ff      <= siren_in;
         rsp_mode_ff       <= mode_in;
         rsp_cancel_ff     <= cancel_in;
         rsp_cancel_src_ff <= cancel_src_in;
         rsp_tally_ff      <= tally_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.siren_out     = rsp_siren_ff;
   assign rsp_chan.alarm_mode    = rsp_mode_ff;
   assign rsp_chan.cancel_valid  = rsp_cancel_ff;
   assign rsp_chan.cancel_source = rsp_cancel_src_ff;
   assign rsp_chan.trigger_count = rsp_tally_ff;

   // siren off means its countdown is empty
   assert property (@(posedge clock) disable iff (reset)
      !siren_ff |-> siren_cd_ff == '0)
      else $error("siren off with countdown running");

   // alarm countdown only runs while active
   assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_ACTIVE |-> alarm_cd_ff == '0)
      else $error("alarm countdown running outside active mode");

   // a cancel always reports the cleared state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_cancel_ff |->
         rsp_mode_ff == MODE_IDLE && !rsp_siren_ff && rsp_tally_ff == '0)
      else $error("cancel reported without cleared state");

   // a response is loaded exactly when a held request moves on
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("response lost after request advanced");

endmodule

[test/tb_top.sv]
// self-checking testbench for the alarm siren controller: directed event table, then random traffic
`timescale 1ns / 1ps
module tb_top;
   import asc_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         RANDOM_PHASES = 8;
   localparam int         PHASE_EVENTS  = 56;

   typedef struct packed {
      logic       siren;
      mode_type   mode;
      logic       cancel_valid;
      logic [3:0] cancel_source;
      logic [4:0] tally;
   } alarm_status_type;

   typedef struct {
      bit               is_write;
      reg_index_type    reg_idx;
      logic [15:0]      wdata;
      logic [1:0]       op;
      logic [3:0]       src;
      bit               typed;
      alarm_status_type status;
   } directed_row_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_we;
   logic [CFG_INDEX_BITS-1:0] csr_index;
   logic [CFG_DATA_BITS-1:0]  csr_wdata;

   asc_req_if req_chan();
   asc_rsp_if rsp_chan();

   alarm_siren_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted controller state and configuration
   mode_type    track_mode;
   logic        track_siren;
   logic [15:0] siren_left;
   logic [15:0] alarm_left;
   logic [4:0]  trigger_tally;
   logic [15:0] siren_len;
   logic [15:0] alarm_len;
   logic [3:0]  alarm_limit;

   alarm_status_type pending_status[$];
   int               fail_count = 0;
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   int               cycle_count = 0;
   alarm_status_type got_status;
   alarm_status_type want_status;

   function automatic alarm_status_type status_of(logic siren, mode_type mode, logic cv,
                                                  logic [3:0] cs, logic [4:0] tally);
      alarm_status_type s;
      s.siren         = siren;
      s.mode          = mode;
      s.cancel_valid  = cv;
      s.cancel_source = cs;
      s.tally         = tally;
      return s;
   endfunction

   function automatic alarm_status_type advance_alarm(logic [1:0] op, logic [3:0] src);
      logic       cv;
      logic [3:0] cs;
      cv = 1'b0;
      cs = 4'd0;
      case (op)
         OP_TICK: begin
            if (siren_left != 16'd0) begin
               siren_left = siren_left - 16'd1;
               if (siren_left == 16'd0) track_siren = 1'b0;
            end
            if (alarm_left != 16'd0) begin
               alarm_left = alarm_left - 16'd1;
               if (alarm_left == 16'd0) track_mode = MODE_TIMEOUT;
            end
         end
         OP_TRIGGER: begin
            if (track_mode != MODE_ACTIVE) begin
               if (trigger_tally <= alarm_limit) trigger_tally = trigger_tally + 5'd1;
               if (trigger_tally <= alarm_limit) begin
                  track_mode = MODE_ACTIVE;
                  alarm_left = alarm_len;
                  if (!track_siren) begin
                     siren_left  = siren_len;
                     track_siren = 1'b1;
                  end
               end
            end
         end
         OP_STOP: begin
            if (track_mode == MODE_ACTIVE) begin
               cv = 1'b1;
               cs = src;
            end
            track_siren   = 1'b0;
            siren_left    = 16'd0;
            alarm_left    = 16'd0;
            trigger_tally = 5'd0;
            track_mode    = MODE_IDLE;
         end
         default: ;
      endcase
      return status_of(track_siren, track_mode, cv, cs, trigger_tally);
   endfunction

   function automatic directed_row_type step_row(logic [1:0] op, logic [3:0] src);
      directed_row_type r;
      r.is_write = 1'b0;
      r.reg_idx  = REG_SIREN_TICKS;
      r.wdata    = '0;
      r.op       = op;
      r.src      = src;
      r.typed    = 1'b0;
      r.status   = '0;
      return r;
   endfunction

   function automatic directed_row_type checked_row(logic [1:0] op, logic [3:0] src,
                                                    alarm_status_type s);
      directed_row_type r;
      r        = step_row(op, src);
      r.typed  = 1'b1;
      r.status = s;
      return r;
   endfunction

   function automatic directed_row_type write_row(reg_index_type idx, logic [15:0] data);
      directed_row_type r;
      r          = step_row(OP_TICK, 4'd0);
      r.is_write = 1'b1;
      r.reg_idx  = idx;
      r.wdata    = data;
      return r;
   endfunction

   task automatic wait_drained();
      do @(posedge clock); while (pending_status.size() != 0);
   endtask

   task automatic send_event(logic [1:0] op, logic [3:0] src, bit typed,
                             alarm_status_type s);
      alarm_status_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= op;
      req_chan.event_source <= src;
      do @(posedge clock); while (!req_chan.ready);
      predicted = advance_alarm(op, src);
      pending_status.push_back(typed ? s : predicted);
   endtask

   task automatic write_reg(reg_index_type idx, logic [15:0] data);
      req_chan.valid <= 1'b0;
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_SIREN_TICKS: siren_len   = data;
         REG_ALARM_TICKS: alarm_len   = data;
         REG_MAX_ALARMS:  alarm_limit = data[3:0];
         default: ;
      endcase
      csr_we <= 1'b0;
   endtask

   task automatic set_profile(int p);
      case (p % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 48; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 48; end
         default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
   endtask

   // response checker and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got_status = status_of(rsp_chan.siren_out, mode_type'(rsp_chan.alarm_mode),
                                rsp_chan.cancel_valid, rsp_chan.cancel_source,
                                rsp_chan.trigger_count);
         if (pending_status.size() == 0) begin
            $error("response transaction with no request outstanding");
            fail_count++;
         end else begin
            want_status = pending_status.pop_front();
            if (got_status.siren !== want_status.siren) begin
               $error("siren_out: expected %0d, got %0d", want_status.siren, got_status.siren);
               fail_count++;
            end
            if (got_status.mode !== want_status.mode) begin
               $error("alarm_mode: expected %0d, got %0d", want_status.mode, got_status.mode);
               fail_count++;
            end
            if (got_status.cancel_valid !== want_status.cancel_valid) begin
               $error("cancel_valid: expected %0d, got %0d",
                      want_status.cancel_valid, got_status.cancel_valid);
               fail_count++;
            end
            if (got_status.cancel_source !== want_status.cancel_source) begin
               $error("cancel_source: expected %0d, got %0d",
                      want_status.cancel_source, got_status.cancel_source);
               fail_count++;
            end
            if (got_status.tally !== want_status.tally) begin
               $error("trigger_count: expected %0d, got %0d", want_status.tally, got_status.tally);
               fail_count++;
            end
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      directed_row_type script[$];
      directed_row_type row;
      int               r;
      logic [1:0]       op;

      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.operation    = OP_TICK;
      req_chan.event_source = 4'd0;
      csr_we                = 1'b0;
      csr_index             = REG_SIREN_TICKS;
      csr_wdata             = '0;

      track_mode    = MODE_IDLE;
      track_siren   = 1'b0;
      siren_left    = 16'd0;
      alarm_left    = 16'd0;
      trigger_tally = 5'd0;
      siren_len     = SIREN_TICKS_RESET;
      alarm_len     = ALARM_TICKS_RESET;
      alarm_limit   = MAX_ALARMS_RESET;

      // defaults after reset
      script.push_back(checked_row(OP_TICK, 4'd0,
                       status_of(1'b0, MODE_IDLE, 1'b0, 4'd0, 5'd0)));
      script.push_back(checked_row(OP_UNUSED, 4'd15,
                       status_of(1'b0, MODE_IDLE, 1'b0, 4'd0, 5'd0)));
      script.push_back(checked_row(OP_STOP, 4'd15,
                       status_of(1'b0, MODE_IDLE, 1'b0, 4'd0, 5'd0)));
      script.push_back(checked_row(OP_TRIGGER, 4'd0,
                       status_of(1'b1, MODE_ACTIVE, 1'b0, 4'd0, 5'd1)));
      script.push_back(checked_row(OP_TRIGGER, 4'd15,
                       status_of(1'b1, MODE_ACTIVE, 1'b0, 4'd0, 5'd1)));
      script.push_back(checked_row(OP_STOP, 4'd15,
                       status_of(1'b0, MODE_IDLE, 1'b1, 4'd15, 5'd0)));
      script.push_back(step_row(OP_TRIGGER, 4'd5));
      script.push_back(checked_row(OP_STOP, 4'd0,
                       status_of(1'b0, MODE_IDLE, 1'b1, 4'd0, 5'd0)));
      // zero limit, tally saturates at one
      script.push_back(write_row(REG_MAX_ALARMS, 16'd0));
      script.push_back(checked_row(OP_TRIGGER, 4'd1,
                       status_of(1'b0, MODE_IDLE, 1'b0, 4'd0, 5'd1)));
      script.push_back(checked_row(OP_TRIGGER, 4'd2,
                       status_of(1'b0, MODE_IDLE, 1'b0, 4'd0, 5'd1)));
      script.push_back(checked_row(OP_STOP, 4'd7,
                       status_of(1'b0, MODE_IDLE, 1'b0, 4'd0, 5'd0)));
      // short timers, expiry and reactivation
      script.push_back(write_row(REG_SIREN_TICKS, 16'd2));
      script.push_back(write_row(REG_ALARM_TICKS, 16'd3));
      script.push_back(write_row(REG_MAX_ALARMS, 16'd15));
      script.push_back(step_row(OP_TRIGGER, 4'd0));
      script.push_back(step_row(OP_TICK, 4'd0));
      script.push_back(step_row(OP_TICK, 4'd0));
      script.push_back(step_row(OP_TICK, 4'd0));
      script.push_back(step_row(OP_TRIGGER, 4'd0));
      script.push_back(step_row(OP_STOP, 4'd9));
      // zero durations never expire
      script.push_back(write_row(REG_SIREN_TICKS, 16'd0));
      script.push_back(write_row(REG_ALARM_TICKS, 16'd0));
      script.push_back(step_row(OP_TRIGGER, 4'd0));
      script.push_back(step_row(OP_TICK, 4'd0));
      script.push_back(step_row(OP_TICK, 4'd0));
      script.push_back(step_row(OP_STOP, 4'd3));
      // retrigger after timeout while siren still on
      script.push_back(write_row(REG_SIREN_TICKS, 16'hFFFF));
      script.push_back(write_row(REG_ALARM_TICKS, 16'd2));
      script.push_back(write_row(REG_MAX_ALARMS, 16'd2));
      script.push_back(step_row(OP_TRIGGER, 4'd0));
      script.push_back(step_row(OP_TICK, 4'd0));
      script.push_back(step_row(OP_TICK, 4'd0));
      script.push_back(step_row(OP_TRIGGER, 4'd0));
      script.push_back(step_row(OP_TRIGGER, 4'd0));
      script.push_back(step_row(OP_STOP, 4'd12));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_profile(0);
      foreach (script[i]) begin
         row = script[i];
         if (row.is_write) write_reg(row.reg_idx, row.wdata);
         else send_event(row.op, row.src, row.typed, row.status);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_profile(0);
         case (p)
            2: begin
               write_reg(REG_SIREN_TICKS, 16'hFFFF);
               write_reg(REG_ALARM_TICKS, 16'd1);
               write_reg(REG_MAX_ALARMS, 16'd15);
            end
            5: begin
               write_reg(REG_SIREN_TICKS, 16'd1);
               write_reg(REG_ALARM_TICKS, 16'hFFFF);
               write_reg(REG_MAX_ALARMS, 16'd0);
            end
            default: begin
               write_reg(REG_SIREN_TICKS, 16'($urandom_range(1, 12)));
               write_reg(REG_ALARM_TICKS, 16'($urandom_range(1, 20)));
               write_reg(REG_MAX_ALARMS, 16'($urandom_range(0, 5)));
            end
         endcase
         set_profile(p);
         for (int n = 0; n < PHASE_EVENTS; n++) begin
            r  = $urandom_range(99);
            op = (r < 55) ? OP_TICK : (r < 80) ? OP_TRIGGER : (r < 92) ? OP_STOP : OP_UNUSED;
            send_event(op, 4'($urandom_range(0, 15)), 1'b0, '0);
         end
      end

      req_chan.valid <= 1'b0;
      wait_drained();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/asc_pkg.sv
hdl/asc_ifs.sv
hdl/alarm_siren_controller.sv
test/tb_top.sv
